@@ rtl/chnf_pkg.sv @@
// Shared types, constants and helpers for the checkerboard hole fill block.
package chnf_pkg;

  localparam int ROWS_DEF = 48;
  localparam int COLS_DEF = 16;

  localparam int PIX_W   = 16;
  localparam int ROW_F_W = 6;
  localparam int COL_F_W = 4;
  localparam int SUM_W   = PIX_W + 2;

  // floor(x / 3) == (x * RECIP3) >> RECIP3_SHIFT for every x below 2**19
  localparam logic [SUM_W-1:0] RECIP3       = 18'd174763;
  localparam int               RECIP3_SHIFT = 19;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;
  } chnf_in_t;

  typedef struct packed {
    logic [ROW_F_W-1:0] out_row;
    logic [COL_F_W-1:0] out_col;
    logic [PIX_W-1:0]   out_value;
    logic               frame_done;
    logic               run_last;
  } chnf_out_t;

  typedef enum logic [1:0] {
    DIV_ONE   = 2'd0,
    DIV_TWO   = 2'd1,
    DIV_THREE = 2'd2,
    DIV_FOUR  = 2'd3
  } chnf_div_t;

  // One pending release: neighbor sum and divisor, or the sample itself.
  typedef struct packed {
    logic [ROW_F_W-1:0] row;
    logic [COL_F_W-1:0] col;
    logic [SUM_W-1:0]   sum;
    chnf_div_t          div;
    logic               done;
    logic               last;
  } chnf_rel_t;

  // has: {right, left, down, up}
  function automatic chnf_rel_t make_rel(
    input logic               hole,
    input logic [PIX_W-1:0]   ctr,
    input logic [PIX_W-1:0]   up,
    input logic [PIX_W-1:0]   dn,
    input logic [PIX_W-1:0]   lf,
    input logic [PIX_W-1:0]   rt,
    input logic [3:0]         has,
    input logic [ROW_F_W-1:0] row,
    input logic [COL_F_W-1:0] col,
    input logic               done
  );
    chnf_rel_t  rel;
    logic [2:0] n;
    rel      = '0;
    rel.row  = row;
    rel.col  = col;
    rel.done = done;
    rel.last = 1'b0;
    n = {2'b0, has[0]} + {2'b0, has[1]} + {2'b0, has[2]} + {2'b0, has[3]};
    if (!hole) begin
      rel.sum = SUM_W'(ctr);
      rel.div = DIV_ONE;
    end else begin
      rel.sum = (has[0] ? SUM_W'(up) : '0) + (has[1] ? SUM_W'(dn) : '0)
              + (has[2] ? SUM_W'(lf) : '0) + (has[3] ? SUM_W'(rt) : '0);
      case (n)
        3'd2:    rel.div = DIV_TWO;
        3'd3:    rel.div = DIV_THREE;
        default: rel.div = DIV_FOUR;
      endcase
    end
    return rel;
  endfunction

endpackage

@@ rtl/chnf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module chnf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/checkerboard_hole_neighbor_fill.sv @@
// Top level: checkerboard hole fill over a row-major pixel stream.
//
//   channel | handshake            | payload      | beat
//   --------+----------------------+--------------+----------------------------
//   in      | in_valid / in_ready  | in_data      | one pixel, row-major
//   out     | out_valid / out_ready| out_data     | one released pixel
//   cfg     | cfg_wr_en            | cfg_wr_data  | hole_parity write, no wait
//
// Interior rows: one pixel per clock in and one result per clock out while out
// is not stalled; a result passes the read stage and the release queue on its
// way to the output register. On the last row the first pixel releases one
// result, the middle ones two and the final one three, and the input waits
// while the single output register sends them out one at a time.
// rst clears positions, hole_parity and all valid flags; the line store needs
// no clearing since releases use only values written earlier in the frame.
// Back-pressure on out fills the release queue, then stalls the read stage,
// then drops in_ready.
module checkerboard_hole_neighbor_fill #(
  parameter int ROWS = chnf_pkg::ROWS_DEF,
  parameter int COLS = chnf_pkg::COLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  chnf_pkg::chnf_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output chnf_pkg::chnf_out_t out_data,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);

  import chnf_pkg::*;

  localparam int RW   = $clog2(ROWS);
  localparam int CW   = $clog2(COLS);
  localparam int ENT_W = 2 * PIX_W;

  // Line store: entry c holds {pixel (r-1, c), pixel (r, c)} once row r
  // has passed column c. The newest row sits in the low half.
  logic              ram_we;
  logic [CW-1:0]     ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [CW-1:0]     ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;

  chnf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (COLS)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Config
  logic hole_parity;

  always_ff @(posedge clk) begin
    if (rst) begin
      hole_parity <= 1'b0;
    end else if (cfg_wr_en) begin
      hole_parity <= cfg_wr_data;
    end
  end

  // Position of the next pixel
  logic [RW-1:0] row_count, row_count_next;
  logic [CW-1:0] col_count, col_count_next;
  logic [RW-1:0] r_in;
  logic [CW-1:0] c_in;
  logic          in_acc;

  assign in_acc = in_valid && in_ready;
  assign r_in   = in_data.frame_start ? '0 : row_count;
  assign c_in   = in_data.frame_start ? '0 : col_count;

  always_comb begin
    row_count_next = r_in;
    col_count_next = c_in + CW'(1);
    if (c_in == CW'(COLS - 1)) begin
      col_count_next = '0;
      row_count_next = (r_in == RW'(ROWS - 1)) ? '0 : r_in + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_acc) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // Read stage: each pixel fetches the column to its right, so the window
  // holds columns c-1, c and c+1 of the two rows above when it retires.
  logic             s1_valid;
  logic [PIX_W-1:0] s1_pix;
  logic [RW-1:0]    s1_r;
  logic [CW-1:0]    s1_c;
  logic             s1_fwd;
  logic [ENT_W-1:0] s1_fwd_data;
  logic [ENT_W-1:0] s1_ent;     // entry c+1
  logic             s1_go;

  logic [ENT_W-1:0] win_c;      // entry c, from the previous pixel's read
  logic [ENT_W-1:0] win_l;      // entry c-1
  logic [PIX_W-1:0] cur_l;      // pixel (r, c-1)
  logic [PIX_W-1:0] cur_ll;     // pixel (r, c-2)

  assign ram_re    = in_acc;
  assign ram_raddr = (c_in == CW'(COLS - 1)) ? '0 : c_in + CW'(1);
  assign ram_we    = s1_go;
  assign ram_waddr = s1_c;
  assign ram_wdata = {win_c[PIX_W-1:0], s1_pix};
  assign s1_ent    = s1_fwd ? s1_fwd_data : ram_rdata;

  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix      <= in_data.pixel_value;
      s1_r        <= r_in;
      s1_c        <= c_in;
      // narrow rows: the entry being written is the one read next
      s1_fwd      <= ram_we && (ram_waddr == ram_raddr);
      s1_fwd_data <= ram_wdata;
    end
    if (s1_go) begin
      win_c  <= s1_ent;
      win_l  <= win_c;
      cur_l  <= s1_pix;
      cur_ll <= cur_l;
    end
  end

  // Releases caused by the pixel in the read stage
  logic        last_row, first_col, last_col;
  logic        par;
  logic [1:0]  n_rel;
  chnf_rel_t   rel_a, rel_b, rel_c;

  assign last_row  = (s1_r == RW'(ROWS - 1));
  assign first_col = (s1_c == '0);
  assign last_col  = (s1_c == CW'(COLS - 1));
  assign par       = s1_r[0] ^ s1_c[0];

  always_comb begin
    if (s1_r == '0) begin
      n_rel = 2'd0;
    end else if (!last_row) begin
      n_rel = 2'd1;
    end else begin
      n_rel = 2'd1 + {1'b0, !first_col} + {1'b0, last_col};
    end
  end

  always_comb begin
    // pixel (r-1, c)
    rel_a = make_rel((par ^ 1'b1) == hole_parity, win_c[PIX_W-1:0],
                     win_c[ENT_W-1:PIX_W], s1_pix, win_l[PIX_W-1:0],
                     s1_ent[PIX_W-1:0],
                     {!last_col, !first_col, 1'b1, s1_r > RW'(1)},
                     ROW_F_W'(s1_r - RW'(1)), COL_F_W'(s1_c), 1'b0);
    // pixel (r, c-1) on the last row
    rel_b = make_rel((par ^ 1'b1) == hole_parity, cur_l, win_l[PIX_W-1:0],
                     s1_pix, cur_ll, s1_pix,
                     {1'b1, s1_c > CW'(1), 1'b0, 1'b1},
                     ROW_F_W'(s1_r), COL_F_W'(s1_c - CW'(1)), 1'b0);
    // pixel (r, c) at the frame's last column
    rel_c = make_rel(par == hole_parity, s1_pix, win_c[PIX_W-1:0],
                     s1_pix, cur_l, s1_pix,
                     4'b0101,
                     ROW_F_W'(s1_r), COL_F_W'(s1_c), 1'b1);
    rel_a.last = (n_rel == 2'd1);
    rel_b.last = (n_rel == 2'd2);
    rel_c.last = (n_rel == 2'd3);
  end

  // Release queue: up to three entries, drained one per output beat
  chnf_rel_t  pend [3];
  logic [1:0] pend_cnt;
  logic       pop;
  logic       q_free;

  assign pop    = (pend_cnt != 2'd0) && (!out_valid || out_ready);
  assign q_free = (pend_cnt == 2'd0) || ((pend_cnt == 2'd1) && pop);
  assign s1_go  = s1_valid && ((n_rel == 2'd0) || q_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= 2'd0;
    end else if (s1_go && (n_rel != 2'd0)) begin
      pend_cnt <= n_rel;
    end else if (pop) begin
      pend_cnt <= pend_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (n_rel != 2'd0)) begin
      pend[0] <= rel_a;
      pend[1] <= rel_b;
      pend[2] <= rel_c;
    end else if (pop) begin
      pend[0] <= pend[1];
      pend[1] <= pend[2];
    end
  end

  // Mean and output register
  logic [2*SUM_W-1:0] prod3;
  logic [PIX_W-1:0]   mean;

  assign prod3 = pend[0].sum * RECIP3;

  always_comb begin
    case (pend[0].div)
      DIV_ONE:   mean = pend[0].sum[PIX_W-1:0];
      DIV_TWO:   mean = pend[0].sum[PIX_W:1];
      DIV_THREE: mean = prod3[RECIP3_SHIFT+PIX_W-1:RECIP3_SHIFT];
      default:   mean = pend[0].sum[PIX_W+1:2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.out_row    <= pend[0].row;
      out_data.out_col    <= pend[0].col;
      out_data.out_value  <= mean;
      out_data.frame_done <= pend[0].done;
      out_data.run_last   <= pend[0].last;
    end
  end

endmodule

@@ sim/chnf_fill_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the hole fill block: predicts released pixels and checks each out beat.
module chnf_fill_checker #(
  parameter int ROWS = chnf_pkg::ROWS_DEF,
  parameter int COLS = chnf_pkg::COLS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  chnf_pkg::chnf_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  chnf_pkg::chnf_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  output int                  fail_count,
  output int                  pending_count,
  output int                  release_count
);
  import chnf_pkg::*;

  // three-row window of the frame, indexed by row mod 3
  logic [PIX_W-1:0] pix_store [3][COLS];
  int unsigned      next_row;
  int unsigned      next_col;
  logic             hole_par;
  chnf_out_t        release_q [$];

  function automatic logic [PIX_W-1:0] filled_value(int unsigned r, int unsigned c);
    int unsigned sum;
    int unsigned cnt;
    sum = 0;
    cnt = 0;
    if (((r + c) % 2) != hole_par) return pix_store[r % 3][c];
    if (r > 0) begin
      sum += pix_store[(r - 1) % 3][c];
      cnt++;
    end
    if (r + 1 < ROWS) begin
      sum += pix_store[(r + 1) % 3][c];
      cnt++;
    end
    if (c > 0) begin
      sum += pix_store[r % 3][c - 1];
      cnt++;
    end
    if (c + 1 < COLS) begin
      sum += pix_store[r % 3][c + 1];
      cnt++;
    end
    return PIX_W'(sum / cnt);
  endfunction

  function automatic chnf_out_t make_release(int unsigned r, int unsigned c);
    chnf_out_t rel;
    rel.out_row    = ROW_F_W'(r);
    rel.out_col    = COL_F_W'(c);
    rel.out_value  = filled_value(r, c);
    rel.frame_done = (r == ROWS - 1) && (c == COLS - 1);
    rel.run_last   = 1'b0;
    return rel;
  endfunction

  // one accepted pixel: store it, release what it completes, step the position
  task automatic predict_pixel(chnf_in_t px);
    chnf_out_t   rel [3];
    int          n;
    int unsigned r;
    int unsigned c;
    n = 0;
    if (px.frame_start) begin
      next_row = 0;
      next_col = 0;
    end
    r = next_row;
    c = next_col;
    pix_store[r % 3][c] = px.pixel_value;
    if (r > 0) begin
      rel[n] = make_release(r - 1, c);
      n++;
    end
    if (r == ROWS - 1) begin
      if (c > 0) begin
        rel[n] = make_release(r, c - 1);
        n++;
      end
      if (c == COLS - 1) begin
        rel[n] = make_release(r, c);
        n++;
      end
    end
    if (n > 0) rel[n - 1].run_last = 1'b1;
    for (int i = 0; i < n; i++) release_q.push_back(rel[i]);
    c++;
    if (c == COLS) begin
      c = 0;
      r = (r + 1 == ROWS) ? 0 : r + 1;
    end
    next_row = r;
    next_col = c;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    chnf_out_t want_rel;
    if (rst) begin
      next_row      = 0;
      next_col      = 0;
      hole_par      = 1'b0;
      fail_count    = 0;
      release_count = 0;
      release_q.delete();
    end else begin
      if (cfg_wr_en) hole_par = cfg_wr_data;
      // out before in: a beat can never be caused by the pixel taken at the same edge
      if (out_valid && out_ready) begin
        release_count++;
        if (release_q.size() == 0) begin
          $error("unexpected release at row %0d col %0d", out_data.out_row, out_data.out_col);
          fail_count++;
        end else begin
          want_rel = release_q.pop_front();
          check_field("out_row", want_rel.out_row, out_data.out_row);
          check_field("out_col", want_rel.out_col, out_data.out_col);
          check_field("out_value", want_rel.out_value, out_data.out_value);
          check_field("frame_done", want_rel.frame_done, out_data.frame_done);
          check_field("run_last", want_rel.run_last, out_data.run_last);
        end
      end
      if (in_valid && in_ready) predict_pixel(in_data);
    end
    pending_count = release_q.size();
  end

endmodule

@@ sim/tb_checkerboard_hole_neighbor_fill.sv @@
`timescale 1ns / 100ps
// Testbench top: feeds pixel frames and parity writes to the hole fill block, gives the verdict.
module tb_checkerboard_hole_neighbor_fill;
  import chnf_pkg::*;

  localparam int ROWS         = ROWS_DEF;
  localparam int COLS         = COLS_DEF;
  localparam int FRAME_PIXELS = ROWS * COLS;
  // read stage + output register + release queue, with margin
  localparam int SETTLE_CYCLES = 12;
  // limit for the whole run, several times the slowest legal run
  localparam int RUN_LIMIT_NS  = 5_000_000;
  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  logic      clk         = 1'b0;
  logic      rst         = 1'b1;
  logic      in_valid    = 1'b0;
  logic      in_ready;
  chnf_in_t  in_data     = '0;
  logic      out_valid;
  logic      out_ready   = 1'b0;
  chnf_out_t out_data;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;

  int fail_count;
  int pending_count;
  int release_count;

  // idle odds in percent, changed only by nonblocking writes
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // stimulus bookkeeping
  int pixels_sent  = 0;
  int frames_done  = 0;
  int restarts     = 0;
  int pixel_pos    = 0;   // next position in the frame, row-major

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  checkerboard_hole_neighbor_fill #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  chnf_fill_checker #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) i_fill_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .release_count(release_count)
  );

  // receiver: random stalls on the out channel
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // hard stop if the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // extremes show up often so neighbor sums hit the top of their range
  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return PIX_MAX;
      default: return PIX_W'($urandom_range(65535));
    endcase
  endfunction

  // one in beat; valid stays up into the next pixel unless the sender idles
  task automatic send_pixel(input logic [PIX_W-1:0] v, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_data.pixel_value   <= v;
    in_data.frame_start   <= fs;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    if (fs) begin
      if (pixel_pos != 0) restarts++;
      pixel_pos = 0;
    end
    pixel_pos = (pixel_pos + 1) % FRAME_PIXELS;
    if (pixel_pos == 0) frames_done++;
  endtask

  // hold off the sender until every predicted beat is out, then let the pipe settle
  task automatic drain_releases();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_parity(input logic p);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // count random pixels; frame_start only on the first; optional mid-run drain
  task automatic send_segment(input int count, input logic first_fs, input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain_releases();
      send_pixel(random_pixel(), (i == 0) ? first_fs : 1'b0);
    end
  endtask

  // a phase: short broken frames, maybe one abandoned in its second row,
  // then four full rows with a drain somewhere in the middle
  task automatic run_phase(input int sidle, input int ridle, input logic parity,
                           input bit deep_abort);
    int len;
    send_idle_pct <= sidle;
    recv_idle_pct <= ridle;
    write_parity(parity);
    repeat (2) begin
      len = $urandom_range(1, COLS / 2);
      // at (0,0) after a whole frame the next frame may follow without frame_start
      send_segment(len, pixel_pos != 0, -1);
    end
    if (deep_abort)
      send_segment($urandom_range(COLS + 1, 2 * COLS), 1'b1, -1);
    send_segment(4 * COLS, 1'b1, $urandom_range(COLS, 3 * COLS));
    drain_releases();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_parity(1'b0);

    // directed: checkerboard of full-scale samples around zero holes, so every
    // hole mean saturates; 2- and 3-neighbor holes on the top edge
    for (int c = 0; c < COLS; c++) send_pixel((c % 2) ? PIX_MAX : '0, c == 0);
    for (int c = 0; c < 6; c++) send_pixel((c % 2) ? '0 : PIX_MAX, 1'b0);
    // restart in mid-frame: unreleased pixels are dropped
    send_pixel(PIX_MAX, 1'b1);
    send_pixel('0, 1'b0);
    drain_releases();

    // receiver-heavy idling, then sender-heavy, then full rate
    run_phase(33, 58, 1'b1, 1'b0);
    run_phase(58, 33, 1'b0, 1'b1);
    run_phase(0, 0, 1'b1, 1'b0);

    $display("Sent %0d pixels: %0d whole frames, %0d mid-frame restarts, both parities.",
             pixels_sent, frames_done, restarts);
    $display("Checked %0d released pixels under sender and receiver stalls.", release_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/chnf_pkg.sv
rtl/chnf_ram.sv
rtl/checkerboard_hole_neighbor_fill.sv
sim/chnf_fill_checker.sv
sim/tb_checkerboard_hole_neighbor_fill.sv
